FILE: src/eel_pkg.sv
// Types and constants shared by the emergency event log modules.
`default_nettype none
package eel_pkg;

	localparam int HISTORY_DEPTH_DEF = 32;
	localparam int RESULT_LIMIT = 32;
	localparam int CNT_W = $clog2(RESULT_LIMIT + 1);

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_LIST   = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [6:0]  node_id;
		logic [15:0] emcy_code;
		logic [7:0]  emcy_reg;
		logic [39:0] vendor_bytes;
		logic [31:0] after_seq;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] event_seq;
		logic [6:0]  event_node;
		logic [15:0] event_code;
		logic [7:0]  event_register;
		logic [39:0] event_vendor;
		logic        last;
		logic [31:0] current_seq;
	} result_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [6:0]  node;
		logic [15:0] code;
		logic [7:0]  register;
		logic [39:0] vendor;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: src/eel_cell.sv
// One storage cell of the event chain: loads a new event or takes its neighbor's.
`default_nettype none
module eel_cell (
	input  wire logic              clk,
	input  eel_pkg::cell_ctl_t     ctl,
	input  eel_pkg::entry_t        nbr,
	input  eel_pkg::entry_t        din,
	output eel_pkg::entry_t        q
);
	import eel_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= din;
		end else if (ctl.shift) begin
			entry_q <= nbr;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

FILE: src/emergency_event_log_unit.sv
// Top level of the emergency event log: control, sequence counter and cell chain.
//
// Usage: drive item and raise start; the item is transferred at a rising edge where
// start is high and busy is low. Results come out on result for one cycle each,
// marked by strobe, and the transfer completes at the edge that ends that cycle;
// the receiver cannot hold results off. The final result of an item has last set.
// A record item is handled in the idle state: its single result appears the cycle after the
// transfer and busy never rises, so a new item may follow at once. An unknown
// command behaves the same and returns one empty result.
// A find or list item rotates the whole chain of HISTORY_DEPTH cells once past the
// head cell, one cell per cycle, then gives the closing result in the flush state;
// busy is high through the scan and the flush state, and the next item can be
// transferred once busy has fallen again.
// List matches stream out during the rotation, each delayed until the next match
// or the closing cycle so that the last one can be marked.
// Reset empties the log and clears the sequence counter to zero; cell contents
// are not cleared, since only the filled part of the chain is ever examined.
`default_nettype none
module emergency_event_log_unit #(
	parameter int HISTORY_DEPTH = eel_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  eel_pkg::item_t     item,
	output logic               busy,
	output logic               strobe,
	output eel_pkg::result_t   result
);
	import eel_pkg::*;

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t             state_q;
	logic [FILL_W-1:0]  fill_q;
	logic [31:0]        seq_q;
	logic [IDX_W-1:0]   step_q;
	logic [CNT_W-1:0]   taken_q;
	entry_t             pend_q;
	logic [6:0]         qnode_q;
	logic [15:0]        qcode_q;
	logic [31:0]        qafter_q;
	logic               qfind_q;
	logic               strobe_q;
	result_t            result_q;

	entry_t             cells [HISTORY_DEPTH];
	cell_ctl_t          ctl [HISTORY_DEPTH];
	entry_t             new_entry;

	logic               accept;
	logic               is_rec;
	logic               full;
	logic [31:0]        seq_next;
	entry_t             head;
	logic               match;
	logic               limit_hit;
	logic               take;

	function automatic result_t empty_result(input logic [31:0] cur);
		result_t r;
		r = '0;
		r.last = 1'b1;
		r.current_seq = cur;
		return r;
	endfunction

	function automatic result_t entry_result(input entry_t e, input logic lst,
			input logic [31:0] cur);
		result_t r;
		r.found = 1'b1;
		r.event_seq = e.seq;
		r.event_node = e.node;
		r.event_code = e.code;
		r.event_register = e.register;
		r.event_vendor = e.vendor;
		r.last = lst;
		r.current_seq = cur;
		return r;
	endfunction

	assign accept = start && (state_q == ST_IDLE);
	assign is_rec = accept && (item.cmd == CMD_RECORD);
	assign full = (fill_q == FILL_W'(HISTORY_DEPTH));
	assign seq_next = (seq_q == '1) ? seq_q : seq_q + 32'd1;

	assign new_entry.seq = seq_next;
	assign new_entry.node = item.node_id;
	assign new_entry.code = item.emcy_code;
	assign new_entry.register = item.emcy_reg;
	assign new_entry.vendor = item.vendor_bytes;

	// Cell 0 holds the oldest event; a scan rotates the chain so every cell passes cell 0.
	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		always_comb begin
			ctl[i].load = is_rec && (full ? (i == HISTORY_DEPTH - 1)
				: (fill_q == FILL_W'(i)));
			ctl[i].shift = (state_q == ST_SCAN) || (is_rec && full);
		end

		eel_cell u_cell (
			.clk (clk),
			.ctl (ctl[i]),
			.nbr (cells[(i + 1) % HISTORY_DEPTH]),
			.din (new_entry),
			.q   (cells[i])
		);
	end

	assign head = cells[0];
	assign match = ({1'b0, step_q} < (IDX_W + 1)'(fill_q))
		&& (head.seq > qafter_q)
		&& (head.node == qnode_q)
		&& (!qfind_q || (head.code == qcode_q));
	assign limit_hit = qfind_q ? (taken_q != '0) : (taken_q == CNT_W'(RESULT_LIMIT));
	assign take = (state_q == ST_SCAN) && match && !limit_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			seq_q <= '0;
			step_q <= '0;
			taken_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.cmd)
							CMD_RECORD: begin
								seq_q <= seq_next;
								if (!full) begin
									fill_q <= fill_q + FILL_W'(1);
								end
								strobe_q <= 1'b1;
								result_q <= entry_result(new_entry, 1'b1, seq_next);
							end
							CMD_FIND, CMD_LIST: begin
								qnode_q <= item.node_id;
								qcode_q <= item.emcy_code;
								qafter_q <= item.after_seq;
								qfind_q <= (item.cmd == CMD_FIND);
								step_q <= '0;
								taken_q <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
								strobe_q <= 1'b1;
								result_q <= empty_result(seq_q);
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (take) begin
						pend_q <= head;
						taken_q <= taken_q + CNT_W'(1);
						// A new match releases the one held back, which is then not the last.
						if (taken_q != '0) begin
							strobe_q <= 1'b1;
							result_q <= entry_result(pend_q, 1'b0, seq_q);
						end
					end
					step_q <= step_q + IDX_W'(1);
					if (step_q == IDX_W'(HISTORY_DEPTH - 1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					strobe_q <= 1'b1;
					result_q <= (taken_q != '0) ? entry_result(pend_q, 1'b1, seq_q)
						: empty_result(seq_q);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_flush_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> strobe)
		else $error("closing cycle of a scan produced no result");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(HISTORY_DEPTH))
		else $error("fill count beyond history depth");

	a_mid_result_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> (state_q != ST_IDLE))
		else $error("non-final result outside a scan");

	a_seq_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (seq_q == $past(seq_q)))
		else $error("sequence counter moved during a query");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_emergency_event_log_unit.sv
// Self-checking testbench for the emergency event log unit: directed table, then random traffic.
module tb_emergency_event_log_unit;
	import eel_pkg::*;

	localparam int DEPTH = HISTORY_DEPTH_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		item_t   cmd_item;
		bit      typed;
		result_t expected;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	// Shadow copy of the event log.
	entry_t      shadow_log [DEPTH];
	int unsigned shadow_oldest = 0;
	int unsigned shadow_fill = 0;
	logic [31:0] shadow_seq = '0;

	result_t     due_results[$];
	result_t     fresh_results[$];
	row_t        directed_rows[$];
	bit          pin_valid = 1'b0;
	result_t     pinned = '0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	emergency_event_log_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	function automatic result_t empty_result(input logic [31:0] cur);
		result_t r;
		r = '0;
		r.last = 1'b1;
		r.current_seq = cur;
		return r;
	endfunction

	function automatic result_t carried(input entry_t e, input bit fin);
		result_t r;
		r.found = 1'b1;
		r.event_seq = e.seq;
		r.event_node = e.node;
		r.event_code = e.code;
		r.event_register = e.register;
		r.event_vendor = e.vendor;
		r.last = fin;
		r.current_seq = shadow_seq;
		return r;
	endfunction

	function automatic result_t stored_result(input logic [31:0] seq, input logic [6:0] node,
			input logic [15:0] code, input logic [7:0] reg_v, input logic [39:0] vend);
		result_t r;
		r.found = 1'b1;
		r.event_seq = seq;
		r.event_node = node;
		r.event_code = code;
		r.event_register = reg_v;
		r.event_vendor = vend;
		r.last = 1'b1;
		r.current_seq = seq;
		return r;
	endfunction

	// Updates the shadow log for one transferred command and fills fresh_results.
	function automatic void run_log_command(input item_t it);
		int unsigned slot;
		int unsigned k;
		bit          hit;
		entry_t      e;
		result_t     r;
		case (it.cmd)
			CMD_RECORD: begin
				if (shadow_seq != 32'hFFFF_FFFF)
					shadow_seq++;
				if (shadow_fill < DEPTH) begin
					slot = (shadow_oldest + shadow_fill) % DEPTH;
					shadow_fill++;
				end else begin
					slot = shadow_oldest;
					shadow_oldest = (shadow_oldest + 1) % DEPTH;
				end
				e.seq = shadow_seq;
				e.node = it.node_id;
				e.code = it.emcy_code;
				e.register = it.emcy_reg;
				e.vendor = it.vendor_bytes;
				shadow_log[slot] = e;
				fresh_results.insert(fresh_results.size(), carried(e, 1'b1));
			end
			CMD_FIND: begin
				hit = 1'b0;
				for (k = 0; k < shadow_fill && !hit; k++) begin
					slot = (shadow_oldest + k) % DEPTH;
					if (shadow_log[slot].seq > it.after_seq && shadow_log[slot].node == it.node_id
							&& shadow_log[slot].code == it.emcy_code) begin
						fresh_results.insert(fresh_results.size(),
							carried(shadow_log[slot], 1'b1));
						hit = 1'b1;
					end
				end
				if (!hit)
					fresh_results.insert(fresh_results.size(), empty_result(shadow_seq));
			end
			CMD_LIST: begin
				for (k = 0; k < shadow_fill && fresh_results.size() < RESULT_LIMIT; k++) begin
					slot = (shadow_oldest + k) % DEPTH;
					if (shadow_log[slot].seq > it.after_seq && shadow_log[slot].node == it.node_id)
						fresh_results.insert(fresh_results.size(),
							carried(shadow_log[slot], 1'b0));
				end
				if (fresh_results.size() == 0) begin
					fresh_results.insert(0, empty_result(shadow_seq));
				end else begin
					r = fresh_results[fresh_results.size() - 1];
					r.last = 1'b1;
					fresh_results[fresh_results.size() - 1] = r;
				end
			end
			default: begin
				fresh_results.insert(fresh_results.size(), empty_result(shadow_seq));
			end
		endcase
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("found=%b seq=%0d node=%0d code=%h reg=%h vendor=%h last=%b current=%0d",
			r.found, r.event_seq, r.event_node, r.event_code, r.event_register, r.event_vendor,
			r.last, r.current_seq);
	endfunction

	function automatic item_t make_item(input logic [1:0] c, input logic [6:0] node,
			input logic [15:0] code, input logic [7:0] reg_v, input logic [39:0] vend,
			input logic [31:0] after);
		item_t it;
		it.cmd = c;
		it.node_id = node;
		it.emcy_code = code;
		it.emcy_reg = reg_v;
		it.vendor_bytes = vend;
		it.after_seq = after;
		return it;
	endfunction

	function automatic void add_row(input item_t it, input bit typed, input result_t res);
		row_t row;
		row.cmd_item = it;
		row.typed = typed;
		row.expected = res;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// Nodes and codes mostly come from a small pool so that queries find matches.
	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			it.cmd = CMD_RECORD;
		else if (pick < 70)
			it.cmd = CMD_FIND;
		else if (pick < 95)
			it.cmd = CMD_LIST;
		else
			it.cmd = CMD_UNUSED;
		if ($urandom_range(0, 9) < 8)
			it.node_id = 7'($urandom_range(0, 3));
		else
			it.node_id = 7'($urandom);
		if ($urandom_range(0, 9) < 8)
			it.emcy_code = 16'(16'h1000 + $urandom_range(0, 3));
		else
			it.emcy_code = 16'($urandom);
		it.emcy_reg = 8'($urandom);
		it.vendor_bytes = {8'($urandom), $urandom};
		pick = $urandom_range(0, 9);
		if (pick < 4)
			it.after_seq = '0;
		else if (pick < 8)
			it.after_seq = $urandom_range(0, shadow_seq);
		else
			it.after_seq = $urandom;
		return it;
	endfunction

	// Called and returns at a falling edge; the item is held until its transfer.
	task automatic send_item(input item_t it, input bit pin, input result_t pin_res,
			input bit steady);
		int unsigned gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(0, 99) < 28)
				gap++;
		repeat (gap) begin
			start = 1'b0;
			item = random_item();
			@(negedge clk);
		end
		item = it;
		pin_valid = pin;
		pinned = pin_res;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (strobe) begin
				if (due_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: %s", show(result));
				end else begin
					want = due_results[0];
					due_results.delete(0);
					if (result.found !== want.found || result.event_seq !== want.event_seq
							|| result.event_node !== want.event_node
							|| result.event_code !== want.event_code
							|| result.event_register !== want.event_register
							|| result.event_vendor !== want.event_vendor
							|| result.last !== want.last
							|| result.current_seq !== want.current_seq) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: expected %s, got %s", show(want), show(result));
					end
				end
			end
			// The shadow log always advances; a typed row replaces only the expectation.
			if (start && !busy) begin
				fresh_results.delete();
				run_log_command(item);
				if (pin_valid) begin
					fresh_results.delete();
					fresh_results.insert(0, pinned);
				end
				foreach (fresh_results[i])
					due_results.insert(due_results.size(), fresh_results[i]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		add_row(make_item(CMD_FIND, 7'd0, 16'h0000, 8'h00, 40'h0, 32'd0), 1'b1, empty_result(0));
		add_row(make_item(CMD_LIST, 7'd127, 16'h0000, 8'h00, 40'h0, 32'd0), 1'b1,
			empty_result(0));
		add_row(make_item(CMD_UNUSED, 7'd127, 16'hFFFF, 8'hFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF),
			1'b1, empty_result(0));
		add_row(make_item(CMD_RECORD, 7'd0, 16'h0000, 8'h00, 40'h0, 32'hFFFF_FFFF), 1'b1,
			stored_result(1, 7'd0, 16'h0000, 8'h00, 40'h0));
		add_row(make_item(CMD_RECORD, 7'd127, 16'hFFFF, 8'hFF, 40'hFF_FFFF_FFFF, 32'd0), 1'b1,
			stored_result(2, 7'd127, 16'hFFFF, 8'hFF, 40'hFF_FFFF_FFFF));
		add_row(make_item(CMD_FIND, 7'd127, 16'hFFFF, 8'h00, 40'h0, 32'd0), 1'b0, '0);
		add_row(make_item(CMD_FIND, 7'd127, 16'hFFFF, 8'h00, 40'h0, 32'd2), 1'b1,
			empty_result(2));
		add_row(make_item(CMD_FIND, 7'd127, 16'h0000, 8'h00, 40'h0, 32'd0), 1'b1,
			empty_result(2));
		add_row(make_item(CMD_FIND, 7'd0, 16'hFFFF, 8'h00, 40'h0, 32'd0), 1'b1, empty_result(2));
		add_row(make_item(CMD_LIST, 7'd0, 16'h0000, 8'h00, 40'h0, 32'd0), 1'b0, '0);
		add_row(make_item(CMD_LIST, 7'd127, 16'h0000, 8'h00, 40'h0, 32'hFFFF_FFFF), 1'b1,
			empty_result(2));
		add_row(make_item(CMD_UNUSED, 7'd0, 16'h0000, 8'h00, 40'h0, 32'd0), 1'b1,
			empty_result(2));
		for (n = 0; n < 4; n++)
			add_row(make_item(CMD_RECORD, 7'd5, 16'h8130, 8'(8'h10 + n),
				40'h01_0203_0400 + 40'(n), 32'd0), 1'b0, '0);
		add_row(make_item(CMD_LIST, 7'd5, 16'h0000, 8'h00, 40'h0, 32'd0), 1'b0, '0);
		add_row(make_item(CMD_LIST, 7'd5, 16'h0000, 8'h00, 40'h0, 32'd4), 1'b0, '0);
		add_row(make_item(CMD_FIND, 7'd5, 16'h8130, 8'h00, 40'h0, 32'd3), 1'b0, '0);
		add_row(make_item(CMD_RECORD, 7'd0, 16'h0000, 8'h5A, 40'hA5_A5A5_A5A5, 32'd0), 1'b0, '0);
		add_row(make_item(CMD_FIND, 7'd0, 16'h0000, 8'h00, 40'h0, 32'd0), 1'b0, '0);
		add_row(make_item(CMD_LIST, 7'd0, 16'h0000, 8'h00, 40'h0, 32'd1), 1'b0, '0);
		add_row(make_item(CMD_RECORD, 7'h2A, 16'h5555, 8'hAA, 40'h55_AA55_AA55, 32'h5555_5555),
			1'b0, '0);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].cmd_item, directed_rows[i].typed,
				directed_rows[i].expected, 1'b0);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// Now and then the sender holds off until the log has answered everything.
			if (n == 100 || n == 300) begin
				start = 1'b0;
				do
					@(negedge clk);
				while (due_results.size() != 0);
			end
			send_item(random_item(), 1'b0, '0, n >= 150 && n < 250);
		end
		start = 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
		mismatch_count += due_results.size();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
src/eel_pkg.sv
src/eel_cell.sv
src/emergency_event_log_unit.sv
sim/tb_emergency_event_log_unit.sv
